>>> rtl/core/clas_pkg.sv
// Shared types, codes and constants of the command line argument splitter.
package clas_pkg;

  // Field widths
  localparam int CH_W   = 8;
  localparam int KIND_W = 2;
  localparam int NUM_W  = 16;
  localparam int PEND_W = 6;
  localparam int PH_W   = 3;
  localparam int QC_W   = 2;

  localparam int MAX_PENDING_BACKSLASH = 62;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END_ARG  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_LINE = 2'd2;

  // Characters of interest
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_BSL   = 8'h5C;

  // Parser phases
  localparam logic [PH_W-1:0] PH_LINE_START   = 3'd0;
  localparam logic [PH_W-1:0] PH_FIRST_QUOTED = 3'd1;
  localparam logic [PH_W-1:0] PH_FIRST_PLAIN  = 3'd2;
  localparam logic [PH_W-1:0] PH_GAP          = 3'd3;
  localparam logic [PH_W-1:0] PH_ARG          = 3'd4;

  // Quote runs count modulo this
  localparam int QUOTE_MOD = 3;

  // Output source select
  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_BS   = 2'd1;
  localparam logic [1:0] SEL_T0   = 2'd2;
  localparam logic [1:0] SEL_T1   = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       dec_bs;
    logic [1:0] sel;
    logic       last;
  } clas_cmd_t;

  // Datapath to controller: shape of an emission plan
  typedef struct packed {
    logic bs_nz;
    logic bs_one;
    logic t0_v;
    logic t1_v;
  } clas_stat_t;

endpackage

>>> rtl/core/clas_in_if.sv
// Input byte channel interface.
interface clas_in_if;
  logic                     valid;
  logic                     ready;
  logic [clas_pkg::CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

>>> rtl/core/clas_out_if.sv
// Result channel interface.
interface clas_out_if;
  logic                        valid;
  logic                        ready;
  logic [clas_pkg::CH_W-1:0]   out_byte;
  logic [clas_pkg::KIND_W-1:0] out_kind;
  logic [clas_pkg::NUM_W-1:0]  arg_number;
  logic                        backslash_overflow;
  logic                        last;

  modport source (output valid, output out_byte, output out_kind, output arg_number,
                  output backslash_overflow, output last, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input arg_number,
                  input backslash_overflow, input last, output ready);
endinterface

>>> rtl/core/command_line_argument_splitter.sv
// Top level of the command line argument splitter.
// The first result beat is offered in the cycle after a byte is taken.
// A new byte is taken only after every result beat of the last byte has been sent;
//   held backslashes are flushed one beat per cycle unless stalled (up to 64 beats per byte).
// Reset (rst_n low, synchronous): parser returns to line start, all counts clear.
module command_line_argument_splitter #(
  parameter int MAX_PENDING_BACKSLASH = clas_pkg::MAX_PENDING_BACKSLASH
) (
  input  logic           clk,
  input  logic           rst_n,
  clas_in_if.sink        in_bus,
  clas_out_if.source     out_bus
);

  clas_pkg::clas_cmd_t  cmd;
  clas_pkg::clas_stat_t st_new;
  clas_pkg::clas_stat_t st_cur;

  clas_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_bus.valid),
    .in_ready_o  (in_bus.ready),
    .out_valid_o (out_bus.valid),
    .out_ready_i (out_bus.ready),
    .st_new_i    (st_new),
    .st_cur_i    (st_cur),
    .cmd_o       (cmd)
  );

  clas_dp #(
    .MaxPend (MAX_PENDING_BACKSLASH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ch_i                 (in_bus.ch),
    .cmd_i                (cmd),
    .st_new_o             (st_new),
    .st_cur_o             (st_cur),
    .out_byte_o           (out_bus.out_byte),
    .out_kind_o           (out_bus.out_kind),
    .arg_number_o         (out_bus.arg_number),
    .backslash_overflow_o (out_bus.backslash_overflow)
  );

  assign out_bus.last = cmd.last;

endmodule

>>> rtl/core/clas_dp.sv
// Datapath: parser state, per-byte emission plan and result payload.
module clas_dp #(
  parameter int MaxPend = clas_pkg::MAX_PENDING_BACKSLASH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [clas_pkg::CH_W-1:0]     ch_i,
  input  clas_pkg::clas_cmd_t           cmd_i,
  output clas_pkg::clas_stat_t          st_new_o,
  output clas_pkg::clas_stat_t          st_cur_o,
  output logic [clas_pkg::CH_W-1:0]     out_byte_o,
  output logic [clas_pkg::KIND_W-1:0]   out_kind_o,
  output logic [clas_pkg::NUM_W-1:0]    arg_number_o,
  output logic                          backslash_overflow_o
);

  localparam int QUOTE_MOD_M1 = clas_pkg::QUOTE_MOD - 1;

  // Parser state
  logic [clas_pkg::PH_W-1:0]   phase_r, phase_nxt;
  logic [clas_pkg::QC_W-1:0]   qc_r, qc_nxt;
  logic [clas_pkg::PEND_W-1:0] pend_r, pend_nxt;
  logic                        iqr_r, iqr_nxt;
  logic [clas_pkg::NUM_W-1:0]  cnt_r, cnt_nxt;
  logic                        ovf_r, ovf_nxt;

  // Emission plan of the byte in flight
  logic [clas_pkg::PEND_W-1:0] bs_r, bs_nxt;
  logic                        t0v_r, t0v_nxt;
  logic [clas_pkg::KIND_W-1:0] t0k_r, t0k_nxt;
  logic [clas_pkg::CH_W-1:0]   t0b_r, t0b_nxt;
  logic                        t1v_r, t1v_nxt;
  logic [clas_pkg::NUM_W-1:0]  idx_r, idx_nxt;
  logic [clas_pkg::NUM_W-1:0]  tot_r, tot_nxt;
  logic                        povf_r, povf_nxt;

  logic is_nul, is_blank, is_q, is_bsl, do_arg, end_ln;
  logic [clas_pkg::QC_W:0] qc_inc;

  assign is_nul   = (ch_i == clas_pkg::CH_NUL);
  assign is_blank = (ch_i == clas_pkg::CH_SPACE) || (ch_i == clas_pkg::CH_TAB);
  assign is_q     = (ch_i == clas_pkg::CH_QUOTE);
  assign is_bsl   = (ch_i == clas_pkg::CH_BSL);

  // Next state and plan for the incoming byte
  always_comb begin
    phase_nxt = phase_r;
    qc_nxt    = qc_r;
    pend_nxt  = pend_r;
    iqr_nxt   = iqr_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    bs_nxt    = '0;
    t0v_nxt   = 1'b0;
    t0k_nxt   = clas_pkg::KIND_BYTE;
    t0b_nxt   = '0;
    t1v_nxt   = 1'b0;
    do_arg    = 1'b0;
    end_ln    = 1'b0;
    qc_inc    = '0;

    case (phase_r)
      clas_pkg::PH_FIRST_QUOTED, clas_pkg::PH_FIRST_PLAIN: begin
        t0v_nxt = 1'b1;
        if (is_nul) begin
          t0k_nxt = clas_pkg::KIND_END_ARG;
          t1v_nxt = 1'b1;
          end_ln  = 1'b1;
        end else if ((phase_r == clas_pkg::PH_FIRST_QUOTED) ? is_q : is_blank) begin
          t0k_nxt   = clas_pkg::KIND_END_ARG;
          phase_nxt = clas_pkg::PH_GAP;
        end else begin
          t0b_nxt = ch_i;
        end
      end
      clas_pkg::PH_GAP: begin
        if (is_nul) begin
          t0v_nxt = 1'b1;
          t0k_nxt = clas_pkg::KIND_END_LINE;
          end_ln  = 1'b1;
        end else if (!is_blank) begin
          if (cnt_r != {clas_pkg::NUM_W{1'b1}}) cnt_nxt = cnt_r + 1'b1;
          phase_nxt = clas_pkg::PH_ARG;
          qc_nxt    = '0;
          pend_nxt  = '0;
          iqr_nxt   = 1'b0;
          do_arg    = 1'b1;
        end
      end
      clas_pkg::PH_ARG: begin
        do_arg = 1'b1;
      end
      default: begin
        if (is_nul) begin
          t0v_nxt = 1'b1;
          t0k_nxt = clas_pkg::KIND_END_LINE;
          end_ln  = 1'b1;
        end else begin
          cnt_nxt = clas_pkg::NUM_W'(1);
          if (is_q) begin
            phase_nxt = clas_pkg::PH_FIRST_QUOTED;
          end else if (is_blank) begin
            t0v_nxt   = 1'b1;
            t0k_nxt   = clas_pkg::KIND_END_ARG;
            phase_nxt = clas_pkg::PH_GAP;
          end else begin
            t0v_nxt   = 1'b1;
            t0b_nxt   = ch_i;
            phase_nxt = clas_pkg::PH_FIRST_PLAIN;
          end
        end
      end
    endcase

    // Inside an argument: backslash and quote rules
    if (do_arg) begin
      if (iqr_nxt && !is_q) begin
        if (qc_nxt == clas_pkg::QC_W'(QUOTE_MOD_M1)) qc_nxt = '0;
        iqr_nxt = 1'b0;
      end
      if (is_nul) begin
        bs_nxt   = pend_nxt;
        pend_nxt = '0;
        t0v_nxt  = 1'b1;
        t0k_nxt  = clas_pkg::KIND_END_ARG;
        t1v_nxt  = 1'b1;
        end_ln   = 1'b1;
      end else if (is_blank && (qc_nxt == '0)) begin
        bs_nxt    = pend_nxt;
        pend_nxt  = '0;
        t0v_nxt   = 1'b1;
        t0k_nxt   = clas_pkg::KIND_END_ARG;
        phase_nxt = clas_pkg::PH_GAP;
      end else if (is_bsl) begin
        if (pend_nxt < clas_pkg::PEND_W'(MaxPend)) pend_nxt = pend_nxt + 1'b1;
        else ovf_nxt = 1'b1;
      end else if (is_q) begin
        if (iqr_nxt) begin
          qc_inc = {1'b0, qc_nxt} + 1'b1;
          if (qc_inc >= (clas_pkg::QC_W + 1)'(clas_pkg::QUOTE_MOD)) begin
            t0v_nxt = 1'b1;
            t0b_nxt = clas_pkg::CH_QUOTE;
            qc_nxt  = '0;
          end else begin
            qc_nxt = qc_inc[clas_pkg::QC_W-1:0];
          end
        end else begin
          bs_nxt = pend_nxt >> 1;
          if (pend_nxt[0]) begin
            t0v_nxt = 1'b1;
            t0b_nxt = clas_pkg::CH_QUOTE;
          end else begin
            qc_nxt = qc_nxt + 1'b1;
          end
          pend_nxt = '0;
          iqr_nxt  = 1'b1;
        end
      end else begin
        bs_nxt   = pend_nxt;
        pend_nxt = '0;
        t0v_nxt  = 1'b1;
        t0b_nxt  = ch_i;
      end
    end

    // Plan fields are taken before the line end clears the state
    idx_nxt  = (cnt_nxt == '0) ? '0 : cnt_nxt - 1'b1;
    tot_nxt  = cnt_nxt;
    povf_nxt = ovf_nxt;

    if (end_ln) begin
      phase_nxt = clas_pkg::PH_LINE_START;
      qc_nxt    = '0;
      pend_nxt  = '0;
      iqr_nxt   = 1'b0;
      cnt_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
  end

  // State registers, committed when a byte is taken; bs_r counts down on each backslash beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= clas_pkg::PH_LINE_START;
      qc_r    <= '0;
      pend_r  <= '0;
      iqr_r   <= 1'b0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      bs_r    <= '0;
      t0v_r   <= 1'b0;
      t1v_r   <= 1'b0;
    end else if (cmd_i.load) begin
      phase_r <= phase_nxt;
      qc_r    <= qc_nxt;
      pend_r  <= pend_nxt;
      iqr_r   <= iqr_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      bs_r    <= bs_nxt;
      t0v_r   <= t0v_nxt;
      t1v_r   <= t1v_nxt;
    end else if (cmd_i.dec_bs) begin
      bs_r <= bs_r - 1'b1;
    end
  end

  // Plan payload
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      t0k_r  <= t0k_nxt;
      t0b_r  <= t0b_nxt;
      idx_r  <= idx_nxt;
      tot_r  <= tot_nxt;
      povf_r <= povf_nxt;
    end
  end

  // Plan shape for the controller
  assign st_new_o = '{bs_nz: (bs_nxt != '0), bs_one: (bs_nxt == clas_pkg::PEND_W'(1)),
                      t0_v: t0v_nxt, t1_v: t1v_nxt};
  assign st_cur_o = '{bs_nz: (bs_r != '0), bs_one: (bs_r == clas_pkg::PEND_W'(1)),
                      t0_v: t0v_r, t1_v: t1v_r};

  // Result payload select
  always_comb begin
    out_byte_o           = '0;
    out_kind_o           = clas_pkg::KIND_END_LINE;
    arg_number_o         = tot_r;
    backslash_overflow_o = povf_r;
    case (cmd_i.sel)
      clas_pkg::SEL_BS: begin
        out_byte_o   = clas_pkg::CH_BSL;
        out_kind_o   = clas_pkg::KIND_BYTE;
        arg_number_o = idx_r;
      end
      clas_pkg::SEL_T0: begin
        out_byte_o   = t0b_r;
        out_kind_o   = t0k_r;
        arg_number_o = (t0k_r == clas_pkg::KIND_END_LINE) ? tot_r : idx_r;
      end
      default: begin
      end
    endcase
  end

  // Held backslashes never pass the limit
  a_pend_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= clas_pkg::PEND_W'(MaxPend))
    else $error("pending backslash count above limit");

  // A backslash flush step only runs on a nonempty count
  a_dec_nz: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.dec_bs |-> (bs_r != '0))
    else $error("backslash flush with empty count");

  // A planned line end always follows an argument end beat
  a_t1_with_t0: assert property (@(posedge clk) disable iff (!rst_n)
    t1v_r |-> t0v_r)
    else $error("line end planned without a leading beat");

endmodule

>>> rtl/core/clas_ctrl.sv
// Controller: takes a byte, then steps through its planned result beats.
module clas_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  clas_pkg::clas_stat_t st_new_i,
  input  clas_pkg::clas_stat_t st_cur_i,
  output clas_pkg::clas_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BS   = 2'd1;
  localparam logic [1:0] S_T0   = 2'd2;
  localparam logic [1:0] S_T1   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       take, beat;

  // First state with something to send
  function automatic logic [1:0] first_of(input logic bs, input logic t0, input logic t1);
    logic [1:0] s;
    if (bs)      s = S_BS;
    else if (t0) s = S_T0;
    else if (t1) s = S_T1;
    else         s = S_IDLE;
    return s;
  endfunction

  assign in_ready_o  = (state_r == S_IDLE);
  assign out_valid_o = (state_r != S_IDLE);
  assign take        = in_valid_i && in_ready_o;
  assign beat        = out_valid_o && out_ready_i;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) state_nxt = first_of(st_new_i.bs_nz, st_new_i.t0_v, st_new_i.t1_v);
      end
      S_BS: begin
        if (beat && st_cur_i.bs_one) state_nxt = first_of(1'b0, st_cur_i.t0_v, st_cur_i.t1_v);
      end
      S_T0: begin
        if (beat) state_nxt = st_cur_i.t1_v ? S_T1 : S_IDLE;
      end
      S_T1: begin
        if (beat) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Commands to the datapath
  always_comb begin
    cmd_o.load   = take;
    cmd_o.dec_bs = beat && (state_r == S_BS);
    cmd_o.sel    = clas_pkg::SEL_NONE;
    cmd_o.last   = 1'b0;
    case (state_r)
      S_BS: begin
        cmd_o.sel  = clas_pkg::SEL_BS;
        cmd_o.last = st_cur_i.bs_one && !st_cur_i.t0_v && !st_cur_i.t1_v;
      end
      S_T0: begin
        cmd_o.sel  = clas_pkg::SEL_T0;
        cmd_o.last = !st_cur_i.t1_v;
      end
      S_T1: begin
        cmd_o.sel  = clas_pkg::SEL_T1;
        cmd_o.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // After the final beat of a byte the block is idle again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && cmd_o.last) |=> in_ready_o)
    else $error("not idle after final beat");

  // A stalled beat keeps the controller where it is
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_o && !out_ready_i) |=> $stable(state_r))
    else $error("state moved during stall");

  // A beat that is not final leaves more to send
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && !cmd_o.last) |=> out_valid_o)
    else $error("results dropped");

endmodule

>>> tb/argv_split_checker.sv
// Watches both channels of the argument splitter, predicts each result beat and compares.
`timescale 1ns / 100ps

module argv_split_checker (
  input  logic clk,
  input  logic rst_n,
  clas_in_if   in_mon,
  clas_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   bytes_taken,
  output int   beats_seen,
  output int   lines_seen,
  output int   lines_dropped,
  output int   peak_args
);

  localparam int MAX_BEATS = 64;

  typedef struct packed {
    logic [clas_pkg::CH_W-1:0]   data;
    logic [clas_pkg::KIND_W-1:0] kind;
    logic [clas_pkg::NUM_W-1:0]  num;
    logic                        ovf;
    logic                        last;
  } split_beat_t;

  // Parser state as the splitter should hold it
  logic [clas_pkg::PH_W-1:0]   ph;
  logic [clas_pkg::QC_W-1:0]   quote_cnt;
  logic [clas_pkg::PEND_W-1:0] held_bsl;
  logic                        in_run;
  logic [clas_pkg::NUM_W-1:0]  n_args;
  logic                        dropped;

  split_beat_t byte_beats[$];
  split_beat_t expected_beats[$];
  int          reported;

  function automatic logic [clas_pkg::NUM_W-1:0] arg_index();
    return (n_args != '0) ? n_args - 1'b1 : '0;
  endfunction

  function automatic logic is_blank(input logic [clas_pkg::CH_W-1:0] c);
    return c == clas_pkg::CH_SPACE || c == clas_pkg::CH_TAB;
  endfunction

  task automatic push_beat(input logic [clas_pkg::KIND_W-1:0] kind,
                           input logic [clas_pkg::CH_W-1:0] data,
                           input logic [clas_pkg::NUM_W-1:0] num);
    split_beat_t b;
    if (byte_beats.size() < MAX_BEATS) begin
      b.data = (kind == clas_pkg::KIND_BYTE) ? data : '0;
      b.kind = kind;
      b.num  = num;
      b.ovf  = dropped;
      b.last = 1'b0;
      byte_beats.push_back(b);
    end
  endtask

  task automatic flush_bsl(input int count);
    for (int i = 0; i < count; i++) push_beat(clas_pkg::KIND_BYTE, clas_pkg::CH_BSL, arg_index());
  endtask

  task automatic clear_parser();
    ph        = clas_pkg::PH_LINE_START;
    quote_cnt = '0;
    held_bsl  = '0;
    in_run    = 1'b0;
    n_args    = '0;
    dropped   = 1'b0;
  endtask

  task automatic close_line();
    push_beat(clas_pkg::KIND_END_LINE, '0, n_args);
    lines_seen++;
    if (dropped) lines_dropped++;
    if (int'(n_args) > peak_args) peak_args = int'(n_args);
    clear_parser();
  endtask

  // One byte of a later argument: backslash and quote run rules
  task automatic arg_char(input logic [clas_pkg::CH_W-1:0] c);
    logic [clas_pkg::QC_W:0] qc_next;
    if (in_run && c != clas_pkg::CH_QUOTE) begin
      if (quote_cnt == 2'd2) quote_cnt = '0;
      in_run = 1'b0;
    end
    if (c == clas_pkg::CH_NUL) begin
      flush_bsl(held_bsl);
      held_bsl = '0;
      push_beat(clas_pkg::KIND_END_ARG, '0, arg_index());
      close_line();
    end else if (is_blank(c) && quote_cnt == '0) begin
      flush_bsl(held_bsl);
      held_bsl = '0;
      push_beat(clas_pkg::KIND_END_ARG, '0, arg_index());
      ph = clas_pkg::PH_GAP;
    end else if (c == clas_pkg::CH_BSL) begin
      if (held_bsl < clas_pkg::MAX_PENDING_BACKSLASH) held_bsl = held_bsl + 1'b1;
      else dropped = 1'b1;
    end else if (c == clas_pkg::CH_QUOTE) begin
      if (in_run) begin
        qc_next = {1'b0, quote_cnt} + 1'b1;
        if (qc_next >= clas_pkg::QUOTE_MOD) begin
          push_beat(clas_pkg::KIND_BYTE, clas_pkg::CH_QUOTE, arg_index());
          quote_cnt = '0;
        end else begin
          quote_cnt = qc_next[clas_pkg::QC_W-1:0];
        end
      end else begin
        flush_bsl(held_bsl >> 1);
        if (held_bsl[0]) push_beat(clas_pkg::KIND_BYTE, clas_pkg::CH_QUOTE, arg_index());
        else quote_cnt = quote_cnt + 1'b1;
        held_bsl = '0;
        in_run   = 1'b1;
      end
    end else begin
      flush_bsl(held_bsl);
      held_bsl = '0;
      push_beat(clas_pkg::KIND_BYTE, c, arg_index());
    end
  endtask

  // Expected beats for one taken byte, appended to the expectation queue
  task automatic split_byte(input logic [clas_pkg::CH_W-1:0] c);
    byte_beats.delete();
    case (ph)
      clas_pkg::PH_FIRST_QUOTED, clas_pkg::PH_FIRST_PLAIN: begin
        if (c == clas_pkg::CH_NUL) begin
          push_beat(clas_pkg::KIND_END_ARG, '0, arg_index());
          close_line();
        end else if ((ph == clas_pkg::PH_FIRST_QUOTED && c == clas_pkg::CH_QUOTE) ||
                     (ph == clas_pkg::PH_FIRST_PLAIN && is_blank(c))) begin
          push_beat(clas_pkg::KIND_END_ARG, '0, arg_index());
          ph = clas_pkg::PH_GAP;
        end else begin
          push_beat(clas_pkg::KIND_BYTE, c, arg_index());
        end
      end
      clas_pkg::PH_GAP: begin
        if (c == clas_pkg::CH_NUL) begin
          close_line();
        end else if (!is_blank(c)) begin
          if (n_args != '1) n_args = n_args + 1'b1;
          ph        = clas_pkg::PH_ARG;
          quote_cnt = '0;
          held_bsl  = '0;
          in_run    = 1'b0;
          arg_char(c);
        end
      end
      clas_pkg::PH_ARG: arg_char(c);
      default: begin
        if (c == clas_pkg::CH_NUL) begin
          close_line();
        end else begin
          n_args = clas_pkg::NUM_W'(1);
          if (c == clas_pkg::CH_QUOTE) begin
            ph = clas_pkg::PH_FIRST_QUOTED;
          end else if (is_blank(c)) begin
            push_beat(clas_pkg::KIND_END_ARG, '0, '0);
            ph = clas_pkg::PH_GAP;
          end else begin
            push_beat(clas_pkg::KIND_BYTE, c, '0);
            ph = clas_pkg::PH_FIRST_PLAIN;
          end
        end
      end
    endcase
    if (byte_beats.size() > 0) byte_beats[byte_beats.size()-1].last = 1'b1;
    foreach (byte_beats[i]) expected_beats.push_back(byte_beats[i]);
  endtask

  initial begin
    clear_parser();
    fail_count    = 0;
    pending       = 0;
    bytes_taken   = 0;
    beats_seen    = 0;
    lines_seen    = 0;
    lines_dropped = 0;
    peak_args     = 0;
    reported      = 0;
  end

  // Predict on each taken byte, then compare each result beat with the oldest expectation
  always @(posedge clk) begin
    split_beat_t got;
    split_beat_t want;
    if (!rst_n) begin
      clear_parser();
      expected_beats.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        bytes_taken++;
        split_byte(in_mon.ch);
      end
      if (out_mon.valid && out_mon.ready) begin
        beats_seen++;
        got = '{out_mon.out_byte, out_mon.out_kind, out_mon.arg_number,
                out_mon.backslash_overflow, out_mon.last};
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: result beat with nothing expected: byte %h kind %0d num %0d ovf %b last %b",
                     $realtime, got.data, got.kind, got.num, got.ovf, got.last);
          end
        end else begin
          want = expected_beats.pop_front();
          if (got.data !== want.data || got.kind !== want.kind || got.num !== want.num ||
              got.ovf !== want.ovf || got.last !== want.last) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch, expected byte %h kind %0d num %0d ovf %b last %b",
                       $realtime, want.data, want.kind, want.num, want.ovf, want.last);
              $display("%0t:           got      byte %h kind %0d num %0d ovf %b last %b",
                       $realtime, got.data, got.kind, got.num, got.ovf, got.last);
            end
          end
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

>>> tb/command_line_argument_splitter_test.sv
// Top of the argument splitter testbench: clock, reset, byte stimulus, result stalls, verdict.
`timescale 1ns / 100ps

module command_line_argument_splitter_test;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_BYTES = 385;

  typedef logic [clas_pkg::CH_W-1:0] line_t[$];

  logic clk;
  logic rst_n;
  logic calm;

  int fail_count;
  int pending;
  int bytes_taken;
  int beats_seen;
  int lines_seen;
  int lines_dropped;
  int peak_args;

  clas_in_if  in_bus();
  clas_out_if out_bus();

  command_line_argument_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  argv_split_checker split_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count   (fail_count),
    .pending      (pending),
    .bytes_taken  (bytes_taken),
    .beats_seen   (beats_seen),
    .lines_seen   (lines_seen),
    .lines_dropped(lines_dropped),
    .peak_args    (peak_args)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reset, held low from the start and released on a falling edge
  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** command_line_argument_splitter: FAILED **");
    $finish;
  end

  // Result side: random stall before each beat, none while calm
  initial begin
    int gap;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 10);
      @(negedge clk);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
    end
  end

  // One byte beat, after a random gap
  task automatic send_char(input logic [clas_pkg::CH_W-1:0] c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.ch    <= c;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  task automatic send_line(input line_t q);
    foreach (q[i]) send_char(q[i]);
  endtask

  // Hold the sender until every expected beat is back
  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [clas_pkg::CH_W-1:0] text_char();
    logic [clas_pkg::CH_W-1:0] c;
    do c = clas_pkg::CH_W'($urandom_range(1, 255));
    while (c == clas_pkg::CH_SPACE || c == clas_pkg::CH_TAB || c == clas_pkg::CH_QUOTE ||
           c == clas_pkg::CH_BSL);
    return c;
  endfunction

  function automatic logic [clas_pkg::CH_W-1:0] blank_char();
    return $urandom_range(0, 1) ? clas_pkg::CH_SPACE : clas_pkg::CH_TAB;
  endfunction

  // Mostly special bytes, sometimes anything
  function automatic logic [clas_pkg::CH_W-1:0] noise_char();
    case ($urandom_range(0, 5))
      0: return clas_pkg::CH_QUOTE;
      1: return clas_pkg::CH_BSL;
      2: return blank_char();
      3: return clas_pkg::CH_NUL;
      default: return clas_pkg::CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  // A random line: mostly well formed arguments with random content, some noise
  function automatic line_t make_line();
    line_t q;
    int    n;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 20);
      repeat (n) q.push_back(noise_char());
      q.push_back(clas_pkg::CH_NUL);
      return q;
    end
    // first argument
    case ($urandom_range(0, 3))
      0: begin
        q.push_back(clas_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 4))
          q.push_back($urandom_range(0, 2) == 0 ? blank_char() : text_char());
        if ($urandom_range(0, 4) != 0) q.push_back(clas_pkg::CH_QUOTE);
      end
      1: q.push_back(blank_char());
      default: begin
        repeat ($urandom_range(1, 4))
          q.push_back($urandom_range(0, 5) == 0 ? noise_char() : text_char());
        if (q[q.size()-1] == clas_pkg::CH_NUL) return q;
      end
    endcase
    // later arguments
    repeat ($urandom_range(0, 4)) begin
      repeat ($urandom_range(1, 2)) q.push_back(blank_char());
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 4))
          0: begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 5);
            repeat (n) q.push_back(clas_pkg::CH_BSL);
            if ($urandom_range(0, 1)) q.push_back(clas_pkg::CH_QUOTE);
          end
          1: repeat ($urandom_range(1, 4)) q.push_back(clas_pkg::CH_QUOTE);
          2: begin
            q.push_back(clas_pkg::CH_QUOTE);
            q.push_back(blank_char());
            q.push_back(text_char());
            if ($urandom_range(0, 3) != 0) q.push_back(clas_pkg::CH_QUOTE);
          end
          default: repeat ($urandom_range(1, 3)) q.push_back(text_char());
        endcase
      end
    end
    if ($urandom_range(0, 3) == 0) q.push_back(blank_char());
    q.push_back(clas_pkg::CH_NUL);
    return q;
  endfunction

  // Stimulus
  initial begin
    line_t line;
    int    sent;
    bit    paused;
    in_bus.valid = 1'b0;
    in_bus.ch    = '0;
    calm         = 1'b0;
    sent         = 0;
    paused       = 1'b0;
    wait (rst_n === 1'b1);

    // Directed: empty line, leading blank, extreme bytes, odd backslashes before a
    // quote, triple quote, first argument quoted, even backslashes opening a quote
    // that is never closed, trailing backslash at the line end
    line = '{clas_pkg::CH_NUL,
             clas_pkg::CH_SPACE, clas_pkg::CH_NUL,
             8'hFF, clas_pkg::CH_TAB, 8'h61, clas_pkg::CH_BSL, clas_pkg::CH_BSL,
             clas_pkg::CH_BSL, clas_pkg::CH_QUOTE, 8'h62,
             clas_pkg::CH_QUOTE, clas_pkg::CH_QUOTE, clas_pkg::CH_QUOTE, clas_pkg::CH_NUL,
             clas_pkg::CH_QUOTE, 8'h01, clas_pkg::CH_QUOTE, 8'h80, clas_pkg::CH_BSL,
             clas_pkg::CH_BSL, clas_pkg::CH_QUOTE, clas_pkg::CH_TAB,
             clas_pkg::CH_BSL, clas_pkg::CH_NUL};
    send_line(line);
    drain();

    // Random lines
    while (sent < RANDOM_BYTES) begin
      line = make_line();
      calm = ($urandom_range(0, 3) == 0);
      send_line(line);
      sent += line.size();
      if ((!paused && sent > RANDOM_BYTES / 2) || $urandom_range(0, 9) == 0) begin
        paused = 1'b1;
        drain();
      end
    end

    // Wind down
    @(negedge clk);
    in_bus.valid <= 1'b0;
    for (int i = 0; i < 50000 && pending != 0; i++) @(negedge clk);
    repeat (10) @(negedge clk);

    if (pending != 0) $display("%0d expected result beats never arrived", pending);
    $display("Run covered %0d byte beats and %0d result beats over %0d lines;", bytes_taken,
             beats_seen, lines_seen);
    $display("%0d lines dropped backslashes, peak argument count %0d.", lines_dropped,
             peak_args);
    if (fail_count == 0 && pending == 0) begin
      $display("** command_line_argument_splitter: PASSED **");
    end else begin
      $display("** command_line_argument_splitter: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/clas_pkg.sv
rtl/core/clas_in_if.sv
rtl/core/clas_out_if.sv
rtl/core/clas_dp.sv
rtl/core/clas_ctrl.sv
rtl/core/command_line_argument_splitter.sv
tb/argv_split_checker.sv
tb/command_line_argument_splitter_test.sv
